[rtl/u8dec_pkg.sv]
// shared types, constants and helper functions for the utf-8 stream decoder
package u8dec_pkg;

  localparam logic [20:0] REPL_CP = 21'h00FFFD;

  typedef enum logic {
    ST_IDLE,
    ST_PEND
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic emit;  // load one result into the output register and drop its bytes
    logic load;  // append the accepted input byte to the window
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic has_result;  // window head holds a decodable sequence now
    logic is_last;     // the head result is the last one for the current byte
    logic out_free;    // output register is empty or being taken this cycle
  } stat_t;

  function automatic logic [2:0] lead_len(input logic [7:0] b);
    logic [2:0] len;
    if (b[7] == 1'b0) begin
      len = 3'd1;
    end else if (b[7:5] == 3'b110) begin
      len = 3'd2;
    end else if (b[7:4] == 4'b1110) begin
      len = 3'd3;
    end else if (b[7:3] == 5'b11110) begin
      len = 3'd4;
    end else begin
      len = 3'd1;
    end
    return len;
  endfunction

  function automatic logic is_cont(input logic [7:0] b);
    return b[7:6] == 2'b10;
  endfunction

  function automatic logic [7:0] to_ank(input logic [20:0] cp);
    logic [7:0] a;
    if (cp >= 21'h20 && cp <= 21'h7E) begin
      a = cp[7:0];
    end else if (cp >= 21'hFF01 && cp <= 21'hFF5E) begin
      a = cp[7:0] + 8'h20;
    end else if (cp >= 21'hFF61 && cp <= 21'hFF9F) begin
      a = cp[7:0] + 8'h40;
    end else if (cp == 21'h00A5) begin
      a = 8'h5C;
    end else begin
      a = 8'h00;
    end
    return a;
  endfunction

endpackage

[rtl/u8dec_ctrl.sv]
// controller state machine for the utf-8 stream decoder
module u8dec_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  u8dec_pkg::stat_t stat,
  output u8dec_pkg::cmd_t  cmd
);

  u8dec_pkg::state_t state;
  u8dec_pkg::state_t state_next;
  logic              can_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= u8dec_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    can_take   = 1'b1;
    state_next = state;
    case (state)
      u8dec_pkg::ST_IDLE: begin
        can_take   = 1'b1;
        cmd.load   = in_valid;
        state_next = in_valid ? u8dec_pkg::ST_PEND : u8dec_pkg::ST_IDLE;
      end
      u8dec_pkg::ST_PEND: begin
        cmd.emit = stat.has_result && stat.out_free;
        // the next byte may enter once the window has nothing more to give
        can_take = !stat.has_result || (cmd.emit && stat.is_last);
        cmd.load = can_take && in_valid;
        if (can_take) begin
          state_next = in_valid ? u8dec_pkg::ST_PEND : u8dec_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = u8dec_pkg::ST_IDLE;
      end
    endcase
  end

  assign in_stall = !can_take;

endmodule

[rtl/u8dec_dp.sv]
// datapath: byte window, head decode, ank mapping and output register
module u8dec_dp (
  input  logic             clk,
  input  logic             rst,
  input  logic [7:0]       byte_in,
  input  logic             stream_end,
  input  u8dec_pkg::cmd_t  cmd,
  output u8dec_pkg::stat_t stat,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [20:0]      code_point,
  output logic [2:0]       bytes_consumed,
  output logic [7:0]       ank_code,
  output logic             run_last
);

  logic [7:0]  win [4];
  logic [7:0]  win_next [4];
  logic [7:0]  hw [4];
  logic [2:0]  count;
  logic [2:0]  count_next;
  logic        flush;

  logic [2:0]  len;
  logic        cont_ok;
  logic [20:0] cp;
  logic [2:0]  used;
  logic [2:0]  rem;
  logic [7:0]  nb0;
  logic [2:0]  shamt;
  logic [2:0]  cnt_after;
  logic [2:0]  src;

  // head bytes, zero past the fill level (flush padding)
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      hw[i] = (3'(i) < count) ? win[i] : 8'h00;
    end
  end

  always_comb begin
    len     = u8dec_pkg::lead_len(hw[0]);
    cont_ok = 1'b1;
    for (int i = 1; i < 4; i++) begin
      if (3'(i) < len && !u8dec_pkg::is_cont(hw[i])) begin
        cont_ok = 1'b0;
      end
    end
    used = 3'd1;
    if (len == 3'd1) begin
      cp = hw[0][7] ? u8dec_pkg::REPL_CP : {13'd0, hw[0]};
    end else if (!cont_ok) begin
      cp = u8dec_pkg::REPL_CP;
    end else begin
      used = len;
      case (len)
        3'd2:    cp = {10'd0, hw[0][4:0], hw[1][5:0]};
        3'd3:    cp = {5'd0, hw[0][3:0], hw[1][5:0], hw[2][5:0]};
        default: cp = {hw[0][2:0], hw[1][5:0], hw[2][5:0], hw[3][5:0]};
      endcase
    end
  end

  // what is left after this result, to tell whether it closes the run
  assign rem = count - used;
  assign nb0 = win[used[1:0]];

  always_comb begin
    stat.has_result = (count != 3'd0) &&
                      (flush || count >= u8dec_pkg::lead_len(hw[0]));
    stat.is_last    = (rem == 3'd0) ||
                      (!flush && rem < u8dec_pkg::lead_len(nb0));
    stat.out_free   = !out_valid || !out_stall;
  end

  // shift out consumed bytes, then append the new one
  assign shamt     = cmd.emit ? used : 3'd0;
  assign cnt_after = count - shamt;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      src         = 3'(i) + shamt;
      win_next[i] = (src < 3'd4) ? win[src[1:0]] : win[i];
    end
    if (cmd.load && cnt_after < 3'd4) begin
      win_next[cnt_after[1:0]] = byte_in;
    end
  end

  assign count_next = cnt_after + ((cmd.load && cnt_after < 3'd4) ? 3'd1 : 3'd0);

  always_ff @(posedge clk) begin
    for (int i = 0; i < 4; i++) begin
      win[i] <= win_next[i];
    end
    if (cmd.load) begin
      flush <= stream_end;
    end
    if (cmd.emit) begin
      code_point     <= cp;
      bytes_consumed <= used;
      ank_code       <= u8dec_pkg::to_ank(cp);
      run_last       <= stat.is_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= 3'd0;
      out_valid <= 1'b0;
    end else begin
      count <= count_next;
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= 3'd4)
    else $error("window fill level out of range");

  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> stat.out_free)
    else $error("result loaded over a beat not yet taken");

  a_load_after_last: assert property (@(posedge clk) disable iff (rst)
    (cmd.load && cmd.emit) |-> stat.is_last)
    else $error("byte appended while the window still owes results");

  a_used_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (bytes_consumed != 3'd0 && bytes_consumed <= 3'd4))
    else $error("bytes consumed out of range");

endmodule

[rtl/utf8_stream_decoder_ank.sv]
// top level of the utf-8 stream decoder with half-width ank mapping
// a result beat passes through the byte window and then the output register before it is presented
// throughput: one byte per cycle while each byte releases at most one code point and the output is not stalled;
//   a byte that releases more than one code point holds the input until its last one is loaded (one decode per cycle)
// a byte that completes no sequence is absorbed with no result beat
// reset (rst, synchronous): controller idle, window empty, output beat invalid
module utf8_stream_decoder_ank (
  input  logic        clk,
  input  logic        rst,
  // byte channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  byte_in,
  input  logic        stream_end,
  // code point channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [20:0] code_point,
  output logic [2:0]  bytes_consumed,
  output logic [7:0]  ank_code,
  output logic        run_last
);

  u8dec_pkg::cmd_t  cmd;
  u8dec_pkg::stat_t stat;

  // controller: idle, or pending while the window still has sequences to decode;
  // a new byte is taken in the same cycle as the last result of the previous one
  u8dec_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  // datapath: four-byte window, head decode, ank lookup and the output register
  // that parts the two channels
  u8dec_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .byte_in        (byte_in),
    .stream_end     (stream_end),
    .cmd            (cmd),
    .stat           (stat),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .code_point     (code_point),
    .bytes_consumed (bytes_consumed),
    .ank_code       (ank_code),
    .run_last       (run_last)
  );

endmodule
